### hw/rtl/rcsr_pkg.sv
// Shared types, constants and decode functions of the RISC-V CSR unit.
package rcsr_pkg;

	localparam int CSR_COUNT = 40;
	localparam int IDX_W = $clog2(CSR_COUNT);

	localparam logic [31:0] MISA_RESET = 32'h4014_0101;

	localparam logic [IDX_W-1:0] IDX_STIMECMP  = IDX_W'(10);
	localparam logic [IDX_W-1:0] IDX_STIMECMPH = IDX_W'(11);
	localparam logic [IDX_W-1:0] IDX_SATP      = IDX_W'(12);
	localparam logic [IDX_W-1:0] IDX_MISA      = IDX_W'(14);
	localparam logic [IDX_W-1:0] IDX_CYCLE     = IDX_W'(29);
	localparam logic [IDX_W-1:0] IDX_TIME      = IDX_W'(30);
	localparam logic [IDX_W-1:0] IDX_CYCLEH    = IDX_W'(31);
	localparam logic [IDX_W-1:0] IDX_TIMEH     = IDX_W'(32);

	localparam logic [1:0] REQ_CSR   = 2'd0;
	localparam logic [1:0] REQ_CYCLE = 2'd1;
	localparam logic [1:0] REQ_TIME  = 2'd2;

	localparam logic [2:0] OP_RW  = 3'd0;
	localparam logic [2:0] OP_RS  = 3'd1;
	localparam logic [2:0] OP_RC  = 3'd2;
	localparam logic [2:0] OP_RWI = 3'd3;
	localparam logic [2:0] OP_RSI = 3'd4;
	localparam logic [2:0] OP_RCI = 3'd5;

	localparam logic [1:0] PRIV_RO = 2'b11;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [2:0]  csr_op;
		logic [11:0] csr_addr;
		logic [4:0]  dest_reg;
		logic [4:0]  src_field;
		logic [31:0] src_value;
		logic [1:0]  priv_level;
		logic [31:0] host_ticks;
	} req_t;

	typedef struct packed {
		logic        illegal;
		logic        rd_write;
		logic [4:0]  rd_number;
		logic [31:0] rd_value;
		logic        tlb_flush;
		logic        timer_pending;
	} rsp_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
		logic [31:0]      data;
	} mem_wr_t;

	typedef struct packed {
		logic             hit;
		logic [IDX_W-1:0] idx;
	} lookup_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	function automatic lookup_t csr_lookup(input logic [11:0] num);
		lookup_t r;
		r.hit = 1'b1;
		r.idx = '0;
		case (num)
			12'h100: r.idx = IDX_W'(0);
			12'h104: r.idx = IDX_W'(1);
			12'h105: r.idx = IDX_W'(2);
			12'h106: r.idx = IDX_W'(3);
			12'h10A: r.idx = IDX_W'(4);
			12'h140: r.idx = IDX_W'(5);
			12'h141: r.idx = IDX_W'(6);
			12'h142: r.idx = IDX_W'(7);
			12'h143: r.idx = IDX_W'(8);
			12'h144: r.idx = IDX_W'(9);
			12'h14D: r.idx = IDX_W'(10);
			12'h15D: r.idx = IDX_W'(11);
			12'h180: r.idx = IDX_W'(12);
			12'h300: r.idx = IDX_W'(13);
			12'h301: r.idx = IDX_W'(14);
			12'h302: r.idx = IDX_W'(15);
			12'h303: r.idx = IDX_W'(16);
			12'h304: r.idx = IDX_W'(17);
			12'h305: r.idx = IDX_W'(18);
			12'h306: r.idx = IDX_W'(19);
			12'h310: r.idx = IDX_W'(20);
			12'h320: r.idx = IDX_W'(21);
			12'h340: r.idx = IDX_W'(22);
			12'h341: r.idx = IDX_W'(23);
			12'h342: r.idx = IDX_W'(24);
			12'h343: r.idx = IDX_W'(25);
			12'h344: r.idx = IDX_W'(26);
			12'h34A: r.idx = IDX_W'(27);
			12'h5A8: r.idx = IDX_W'(28);
			12'hC00: r.idx = IDX_W'(29);
			12'hC01: r.idx = IDX_W'(30);
			12'hC80: r.idx = IDX_W'(31);
			12'hC81: r.idx = IDX_W'(32);
			12'hF11: r.idx = IDX_W'(33);
			12'hF12: r.idx = IDX_W'(34);
			12'hF13: r.idx = IDX_W'(35);
			12'hF14: r.idx = IDX_W'(36);
			12'hF15: r.idx = IDX_W'(37);
			12'h30A: r.idx = IDX_W'(38);
			12'h31A: r.idx = IDX_W'(39);
			default: r.hit = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] entry_init_value(input logic [IDX_W-1:0] idx);
		return (idx == IDX_MISA) ? MISA_RESET : 32'h0;
	endfunction

endpackage

### hw/rtl/rcsr_mem.sv
// CSR storage: synchronous memory with per-entry valid bits over reset values.
module rcsr_mem (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rd_en,
	input  logic [rcsr_pkg::IDX_W-1:0]  rd_idx,
	output logic [31:0]                 rd_data,
	input  rcsr_pkg::mem_wr_t           wr
);
	import rcsr_pkg::*;

	logic [31:0]          mem [CSR_COUNT];
	logic [CSR_COUNT-1:0] vld_q;
	logic [31:0]          raw_q;
	logic                 raw_vld_q;
	logic [IDX_W-1:0]     raw_idx_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.idx] <= wr.data;
		end
		if (rd_en) begin
			raw_q     <= mem[rd_idx];
			raw_idx_q <= rd_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			raw_vld_q <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.idx] <= 1'b1;
			end
			if (rd_en) begin
				raw_vld_q <= vld_q[rd_idx];
			end
		end
	end

	assign rd_data = raw_vld_q ? raw_q : entry_init_value(raw_idx_q);

endmodule

### hw/rtl/riscv_csr_unit_core.sv
// Top level of the RISC-V CSR unit: request decode, read-modify-write and counters.
// A taken request is captured into the req_s1 registers; its result is then registered
// into the response register in the execute state. A new request is taken only in idle,
// after the last one has left execute; output back-pressure holds the unit in execute.
// Reset: counters, timer flag and entry valid bits clear at once; misa reads its
// reset value and all other CSRs read zero until written. time_scale resets to 1.
module riscv_csr_unit_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  rcsr_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output rcsr_pkg::rsp_t  rsp,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [15:0]     cfg_data
);
	import rcsr_pkg::*;

	state_t           state_q, state_d;
	logic [15:0]      time_scale_q;
	logic [63:0]      cycle_q;
	logic [63:0]      time_q;
	logic [63:0]      stimecmp_q;
	logic             stimer_q;
	req_t             req_s1;
	logic             hit_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [47:0]      prod_s1;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	logic        req_fire;
	logic        exec_fire;
	lookup_t     lk;
	logic [31:0] mem_rdata;
	mem_wr_t     mem_wr;

	logic        imm;
	logic        writes;
	logic        op_bad;
	logic        ill;
	logic [31:0] operand;
	logic [31:0] old_val;
	logic [31:0] new_val;
	logic [63:0] time_new;
	logic        flag_new;
	logic        csr_wr;
	rsp_t        rsp_d;

	assign req_fire  = req_valid && req_ready;
	assign lk        = csr_lookup(req.csr_addr);
	assign cfg_ready = 1'b1;

	rcsr_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (req_fire),
		.rd_idx  (lk.idx),
		.rd_data (mem_rdata),
		.wr      (mem_wr)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (exec_fire) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		exec_fire = 1'b0;
		case (state_q)
			ST_IDLE: req_ready = 1'b1;
			ST_EXEC: exec_fire = !rsp_valid_q || rsp_ready;
			default: begin
				req_ready = 1'b0;
				exec_fire = 1'b0;
			end
		endcase
	end

	always_comb begin
		imm     = req_s1.csr_op inside {OP_RWI, OP_RSI, OP_RCI};
		op_bad  = !(req_s1.csr_op inside {[OP_RW:OP_RCI]});
		operand = imm ? {27'h0, req_s1.src_field} : req_s1.src_value;
		writes  = (req_s1.csr_op == OP_RW) || (req_s1.csr_op == OP_RWI)
			|| (req_s1.src_field != 5'd0);
		ill = !hit_s1 || op_bad
			|| (req_s1.priv_level < req_s1.csr_addr[9:8])
			|| (writes && (req_s1.csr_addr[11:10] == PRIV_RO));

		case (idx_s1)
			IDX_CYCLE:  old_val = cycle_q[31:0];
			IDX_CYCLEH: old_val = cycle_q[63:32];
			IDX_TIME:   old_val = time_q[31:0];
			IDX_TIMEH:  old_val = time_q[63:32];
			default:    old_val = mem_rdata;
		endcase

		case (req_s1.csr_op)
			OP_RS, OP_RSI: new_val = old_val | operand;
			OP_RC, OP_RCI: new_val = old_val & ~operand;
			default:       new_val = operand;
		endcase

		time_new = time_q + {16'h0, prod_s1};
		flag_new = (time_new > stimecmp_q) && (stimecmp_q != 64'h0);

		csr_wr = 1'b0;
		rsp_d  = '0;
		rsp_d.timer_pending = stimer_q;
		case (req_s1.req_type)
			REQ_CSR: begin
				rsp_d.illegal = ill;
				if (!ill) begin
					csr_wr          = writes;
					rsp_d.tlb_flush = writes && (idx_s1 == IDX_SATP);
					if (req_s1.dest_reg != 5'd0) begin
						rsp_d.rd_write  = 1'b1;
						rsp_d.rd_number = req_s1.dest_reg;
						rsp_d.rd_value  = old_val;
					end
				end
			end
			REQ_TIME: rsp_d.timer_pending = flag_new;
			default: rsp_d.illegal = 1'b0;
		endcase

		mem_wr.en   = exec_fire && csr_wr;
		mem_wr.idx  = idx_s1;
		mem_wr.data = new_val;
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			req_s1  <= req;
			hit_s1  <= lk.hit;
			idx_s1  <= lk.idx;
			prod_s1 <= time_scale_q * req.host_ticks;
		end
		if (exec_fire) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			time_scale_q <= 16'd1;
			cycle_q      <= '0;
			time_q       <= '0;
			stimecmp_q   <= '0;
			stimer_q     <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				time_scale_q <= cfg_data;
			end
			if (exec_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (exec_fire && (req_s1.req_type == REQ_CYCLE)) begin
				cycle_q <= cycle_q + 64'd1;
			end
			if (exec_fire && (req_s1.req_type == REQ_TIME)) begin
				time_q   <= time_new;
				stimer_q <= flag_new;
			end
			if (mem_wr.en && (idx_s1 == IDX_STIMECMP)) begin
				stimecmp_q[31:0] <= new_val;
			end
			if (mem_wr.en && (idx_s1 == IDX_STIMECMPH)) begin
				stimecmp_q[63:32] <= new_val;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	a_accept_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> (state_q == ST_EXEC))
		else $error("accepted request did not enter execute");

	a_wr_only_on_fire: assert property (@(posedge clk) disable iff (!arst_n)
		mem_wr.en |-> (exec_fire && (req_s1.req_type == REQ_CSR) && !ill))
		else $error("CSR memory written outside a legal instruction");

	a_rd_fields_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.rd_write) |-> ((rsp.rd_number == 5'd0) && (rsp.rd_value == 32'h0)))
		else $error("rd fields set without rd write");

	a_flush_not_illegal: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.tlb_flush && rsp.illegal))
		else $error("flush raised by illegal instruction");

	a_cycle_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cycle_q != $past(cycle_q)) |-> (cycle_q == $past(cycle_q) + 64'd1))
		else $error("cycle counter jumped");
`endif

endmodule
